// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

  // sizes
  localparam int FRAMES  = 32;
  localparam int PAGE_W  = 7;
  localparam int PAGES   = 1 << PAGE_W;
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FILL_W  = $clog2(FRAMES + 1);
  localparam int CNT_W   = 16;
  localparam int LIM_W   = 6;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register map, word index taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(32);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SEARCH,
    ST_REPLACE
  } state_t;

  // running candidate handed along the cell chain
  typedef struct packed {
    logic               vld;
    logic [FRAME_W-1:0] idx;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   stamp;
    logic [PAGE_W-1:0]  page;
  } best_t;

  // frame update from the controller
  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] idx;
    logic [PAGE_W-1:0]  page;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   stamp;
  } frame_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// ===== sv/lfu_cell.sv =====
module lfu_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lfu_pkg::FRAME_W-1:0] idx,
  input  logic                       filled,
  input  logic                       wr_en,
  input  lfu_pkg::frame_wr_t         wr,
  input  logic [lfu_pkg::PAGE_W-1:0] look_page,
  input  lfu_pkg::best_t             best_in,
  output logic                       hit,
  output lfu_pkg::best_t             best_out
);

  logic [lfu_pkg::PAGE_W-1:0] page_r;
  logic [lfu_pkg::CNT_W-1:0]  cnt_r;
  logic [lfu_pkg::CNT_W-1:0]  stamp_r;
  lfu_pkg::best_t             best_r;
  lfu_pkg::best_t             best_nxt;
  logic                       take_own;

  // resident page with its cached count and stamp
  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_r  <= wr.page;
      cnt_r   <= wr.cnt;
      stamp_r <= wr.stamp;
    end
  end

  assign hit = filled && (page_r == look_page);

  // lower count wins, then older stamp; on a full tie keep the incoming candidate so the lower frame wins
  always_comb begin
    take_own = filled && (!best_in.vld || (cnt_r < best_in.cnt) ||
               ((cnt_r == best_in.cnt) && (stamp_r < best_in.stamp)));
    if (take_own) begin
      best_nxt.vld   = 1'b1;
      best_nxt.idx   = idx;
      best_nxt.cnt   = cnt_r;
      best_nxt.stamp = stamp_r;
      best_nxt.page  = page_r;
    end else begin
      best_nxt = best_in;
    end
  end

  // candidate handed to the next cell, only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.vld <= 1'b0;
    end else begin
      best_r.vld <= best_nxt.vld;
    end
    best_r.idx   <= best_nxt.idx;
    best_r.cnt   <= best_nxt.cnt;
    best_r.stamp <= best_nxt.stamp;
    best_r.page  <= best_nxt.page;
  end

  assign best_out = best_r;

endmodule

// ===== sv/lfu_chain.sv =====
module lfu_chain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lfu_pkg::FILL_W-1:0]  filled_cnt,
  input  lfu_pkg::frame_wr_t          wr,
  input  logic [lfu_pkg::PAGE_W-1:0]  look_page,
  output logic                        hit,
  output logic [lfu_pkg::FRAME_W-1:0] hit_idx,
  output lfu_pkg::best_t              best
);

  lfu_pkg::best_t                link [lfu_pkg::FRAMES+1];
  logic [lfu_pkg::FRAMES-1:0]    hit_vec;

  // empty candidate enters the head of the chain
  assign link[0] = '0;

  for (genvar i = 0; i < lfu_pkg::FRAMES; i++) begin : g_cell
    lfu_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (lfu_pkg::FRAME_W'(i)),
      .filled    (lfu_pkg::FILL_W'(i) < filled_cnt),
      .wr_en     (wr.en && (wr.idx == lfu_pkg::FRAME_W'(i))),
      .wr        (wr),
      .look_page (look_page),
      .best_in   (link[i]),
      .hit       (hit_vec[i]),
      .best_out  (link[i+1])
    );
  end

  // lowest matching frame
  always_comb begin
    hit_idx = '0;
    for (int i = lfu_pkg::FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = lfu_pkg::FRAME_W'(i);
      end
    end
  end

  assign hit  = |hit_vec;
  assign best = link[lfu_pkg::FRAMES];

endmodule

// ===== sv/lfu_page_replacement_top.sv =====
// channel  | ports                                  | direction
// ---------+----------------------------------------+----------
// input    | in_valid, in_ready, in_page            | in
// result   | out_valid, out_ready, out_fault ...    | out
// config   | psel, penable, pwrite, paddr, pwdata   | in
//
// a hit or a fill passes through accept, then lookup across all frame cells
// a replacement passes through accept, lookup, search and replace: the victim minimum walks the cell chain
// one frame per cycle before the frame is rewritten
// reset clears the per-page count table at once through valid bits, no sweep
// a full result register holds the transaction in lookup or replace until taken
module lfu_page_replacement_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lfu_pkg::PAGE_W-1:0]  in_page,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_fault,
  output logic [lfu_pkg::FRAME_W-1:0] out_frame,
  output logic                        out_evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0]  out_evicted_page,
  output logic [lfu_pkg::FILL_W-1:0]  out_resident_count,
  output logic [lfu_pkg::CNT_W-1:0]   out_fault_total,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]  paddr,
  input  logic [lfu_pkg::DATA_W-1:0]  pwdata,
  output logic [lfu_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  lfu_pkg::state_t               state_r, state_nxt;
  logic [lfu_pkg::PAGE_W-1:0]    page_r;
  logic [lfu_pkg::CNT_W-1:0]     rd_cnt_r;
  logic                          rd_vld_r;
  logic [lfu_pkg::CNT_W-1:0]     cnt_mem [lfu_pkg::PAGES];
  logic [lfu_pkg::PAGES-1:0]     cnt_vld_r;
  logic [lfu_pkg::FRAME_W-1:0]   search_r, search_nxt;
  logic [lfu_pkg::FILL_W-1:0]    filled_r;
  logic [lfu_pkg::CNT_W-1:0]     time_r;
  logic [lfu_pkg::CNT_W-1:0]     faults_r;
  logic [lfu_pkg::LIM_W-1:0]     limit_r;
  logic [lfu_pkg::FILL_W-1:0]    lim;
  logic [lfu_pkg::CNT_W-1:0]     new_cnt;
  logic [lfu_pkg::CNT_W-1:0]     new_time;
  logic                          in_acc, out_free, fill_ok, cfg_wr;
  logic                          hit;
  logic [lfu_pkg::FRAME_W-1:0]   hit_idx;
  lfu_pkg::best_t                best;
  lfu_pkg::frame_wr_t            wr;
  logic                          fin, fin_fault, fin_fill, fin_evict;
  logic [lfu_pkg::FRAME_W-1:0]   fin_idx;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lfu_pkg::LIM_RESET;
    end else if (cfg_wr && (paddr[2] == lfu_pkg::REG_FRAMES_IN_USE)) begin
      limit_r <= pwdata[lfu_pkg::LIM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lfu_pkg::REG_FRAMES_IN_USE) begin
      prdata = lfu_pkg::DATA_W'(limit_r);
    end
  end

  // effective limit, zero means one, clipped to the frame count
  always_comb begin
    if (limit_r == '0) begin
      lim = lfu_pkg::FILL_W'(1);
    end else if (lfu_pkg::DATA_W'(limit_r) > lfu_pkg::DATA_W'(lfu_pkg::FRAMES)) begin
      lim = lfu_pkg::FILL_W'(lfu_pkg::FRAMES);
    end else begin
      lim = lfu_pkg::FILL_W'(limit_r);
    end
  end

  assign fill_ok  = filled_r < lim;
  assign new_cnt  = rd_vld_r ? lfu_pkg::sat_inc(rd_cnt_r) : lfu_pkg::CNT_W'(1);
  assign new_time = lfu_pkg::sat_inc(time_r);

  // per-page count table, read at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_cnt_r <= cnt_mem[in_page];
      rd_vld_r <= cnt_vld_r[in_page];
      page_r   <= in_page;
    end
    if (fin) begin
      cnt_mem[page_r] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (fin) begin
      cnt_vld_r[page_r] <= 1'b1;
    end
  end

  // frame cells
  assign wr.en    = fin;
  assign wr.idx   = fin_idx;
  assign wr.page  = page_r;
  assign wr.cnt   = new_cnt;
  assign wr.stamp = new_time;

  lfu_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .filled_cnt (filled_r),
    .wr         (wr),
    .look_page  (page_r),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .best       (best)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lfu_pkg::ST_LOOKUP;
      end
      lfu_pkg::ST_LOOKUP: begin
        if (hit || fill_ok) begin
          if (out_free) state_nxt = lfu_pkg::ST_IDLE;
        end else begin
          state_nxt = lfu_pkg::ST_SEARCH;
        end
      end
      lfu_pkg::ST_SEARCH: begin
        if (search_r == lfu_pkg::FRAME_W'(lfu_pkg::FRAMES - 1)) begin
          state_nxt = lfu_pkg::ST_REPLACE;
        end
      end
      lfu_pkg::ST_REPLACE: begin
        if (out_free) state_nxt = lfu_pkg::ST_IDLE;
      end
      default: state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    fin        = 1'b0;
    fin_fault  = 1'b0;
    fin_fill   = 1'b0;
    fin_evict  = 1'b0;
    fin_idx    = hit_idx;
    search_nxt = '0;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lfu_pkg::ST_LOOKUP: begin
        if (hit) begin
          fin = out_free;
        end else if (fill_ok) begin
          fin       = out_free;
          fin_fault = 1'b1;
          fin_fill  = 1'b1;
          fin_idx   = filled_r[lfu_pkg::FRAME_W-1:0];
        end
      end
      lfu_pkg::ST_SEARCH: begin
        search_nxt = search_r + lfu_pkg::FRAME_W'(1);
      end
      lfu_pkg::ST_REPLACE: begin
        fin       = out_free;
        fin_fault = 1'b1;
        fin_evict = 1'b1;
        fin_idx   = best.idx;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lfu_pkg::ST_IDLE;
      search_r <= '0;
      filled_r <= '0;
      time_r   <= '0;
      faults_r <= '0;
    end else begin
      state_r  <= state_nxt;
      search_r <= search_nxt;
      if (fin) begin
        time_r <= new_time;
        if (fin_fault) faults_r <= lfu_pkg::sat_inc(faults_r);
        if (fin_fill) filled_r <= filled_r + lfu_pkg::FILL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_fault          <= fin_fault;
      out_frame          <= fin_idx;
      out_evicted_valid  <= fin_evict;
      out_evicted_page   <= fin_evict ? best.page : '0;
      out_resident_count <= fin_fill ? filled_r + lfu_pkg::FILL_W'(1) : filled_r;
      out_fault_total    <= fin_fault ? lfu_pkg::sat_inc(faults_r) : faults_r;
    end
  end

endmodule
